// ===== hdl/http_request_field_tagger_macros.svh =====
// Assertion macros shared by the HTTP request field tagger.
`ifndef HTTP_REQUEST_FIELD_TAGGER_MACROS_SVH
`define HTTP_REQUEST_FIELD_TAGGER_MACROS_SVH

// Checks that cons holds in the same cycle whenever ante holds.
`define HRFT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hrft: same-cycle check failed");

// Checks that cons holds in the cycle after ante.
`define HRFT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hrft: next-cycle check failed");

`endif

// ===== hdl/hrft_pkg.sv =====
// Types, constants and helper functions of the HTTP request field tagger.
package hrft_pkg;

    localparam int MAX_QUERIES = 16;
    localparam int MAX_HEADERS = 64;
    localparam int NUM_METHODS = 9;
    localparam logic [3:0] METHOD_UNKNOWN = 4'd9;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // ASCII codes the parser reacts to.
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [0:NUM_METHODS-1][0:7][7:0] METHOD_NAMES = '{
        '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"D", "E", "L", "E", "T", "E", 8'h00, 8'h00},
        '{"C", "O", "N", "N", "E", "C", "T", 8'h00},
        '{"O", "P", "T", "I", "O", "N", "S", 8'h00},
        '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
        '{"P", "A", "T", "C", "H", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [0:NUM_METHODS-1][2:0] METHOD_LENS = '{
        3'd3, 3'd4, 3'd4, 3'd3, 3'd6, 3'd7, 3'd7, 3'd5, 3'd5
    };

    typedef enum logic [2:0] {
        CLS_METHOD = 3'd0,
        CLS_PATH   = 3'd1,
        CLS_QKEY   = 3'd2,
        CLS_QVAL   = 3'd3,
        CLS_HKEY   = 3'd4,
        CLS_HVAL   = 3'd5,
        CLS_BODY   = 3'd6,
        CLS_DELIM  = 3'd7
    } t_class;

    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_PREPATH = 4'd1,
        PH_PATH    = 4'd2,
        PH_QKEY    = 4'd3,
        PH_QVAL    = 4'd4,
        PH_VERSION = 4'd5,
        PH_HKEY    = 4'd6,
        PH_HVAL    = 4'd7,
        PH_BODY    = 4'd8
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_request;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] byte_class;
        logic [5:0] item_index;
        logic       item_end;
        logic [3:0] method_code;
        logic       method_done;
        logic       no_separator;
        logic [4:0] query_total;
        logic [6:0] header_total;
        logic       count_overflow;
        logic       last;
    } t_out_word;

    // What the parser hands to the output queue for one accepted input word.
    typedef struct packed {
        logic      push_pend;
        logic      push_cur;
        t_out_word pend_word;
        t_out_word cur_word;
    } t_push;

    function automatic logic [5:0] clamp_index(input logic [6:0] v);
        return (v > 7'd63) ? 6'd63 : v[5:0];
    endfunction

endpackage

// ===== hdl/hrft_parser.sv =====
// Byte classifier: parse phase, method matcher, counters and the one-word hold-back.
module hrft_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  hrft_pkg::t_in_word i_word,
    output hrft_pkg::t_push  o_push
);

    hrft_pkg::t_phase          r_phase, n_phase;
    logic [hrft_pkg::NUM_METHODS-1:0] r_match, n_match;
    logic [3:0]                r_pos, n_pos;
    logic [4:0]                r_qcnt, n_qcnt;
    logic [6:0]                r_hcnt, n_hcnt;
    logic [1:0]                r_blank, n_blank;
    logic                      r_sep, n_sep;
    logic                      r_ovf, n_ovf;
    logic                      r_pend_valid;
    hrft_pkg::t_out_word       r_pend;

    logic [7:0]                b;
    logic                      colon_space;
    logic                      blank_line;
    logic [3:0]                method_res;
    hrft_pkg::t_out_word       cur;
    hrft_pkg::t_out_word       pend_out;

    assign b = i_word.in_byte;

    // A ':' held back in a header key becomes the separator when a space follows.
    assign colon_space = (r_phase == hrft_pkg::PH_HKEY) && r_pend_valid &&
                         (r_pend.byte_class == hrft_pkg::CLS_HKEY) &&
                         (r_pend.data_byte == hrft_pkg::CH_COLON) && (b == hrft_pkg::CH_SP);

    always_comb begin
        pend_out = r_pend;
        if (colon_space) begin
            pend_out.byte_class = hrft_pkg::CLS_DELIM;
            pend_out.item_end   = 1'b1;
        end
    end

    always_comb begin
        method_res = hrft_pkg::METHOD_UNKNOWN;
        for (int k = hrft_pkg::NUM_METHODS - 1; k >= 0; k--) begin
            if (r_match[k] && ({1'b0, hrft_pkg::METHOD_LENS[k]} == r_pos)) begin
                method_res = 4'(k);
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_match    = r_match;
        n_pos      = r_pos;
        n_qcnt     = r_qcnt;
        n_hcnt     = r_hcnt;
        n_sep      = r_sep;
        n_ovf      = r_ovf;
        blank_line = 1'b0;

        cur                = '0;
        cur.data_byte      = b;
        cur.byte_class     = hrft_pkg::CLS_DELIM;
        cur.last           = i_word.end_of_request;

        if (b == hrft_pkg::CH_CR) begin
            n_blank = (r_blank == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == hrft_pkg::CH_LF) begin
            blank_line = (r_blank == 2'd3);
            n_blank    = (r_blank == 2'd1) ? 2'd2 : 2'd0;
        end else begin
            n_blank = 2'd0;
        end

        unique case (r_phase)
            hrft_pkg::PH_METHOD: begin
                if (b == hrft_pkg::CH_SP || b == hrft_pkg::CH_LF) begin
                    cur.method_done = 1'b1;
                    cur.method_code = (b == hrft_pkg::CH_SP) ? method_res
                                                             : hrft_pkg::METHOD_UNKNOWN;
                    n_phase = (b == hrft_pkg::CH_SP) ? hrft_pkg::PH_PREPATH
                                                     : hrft_pkg::PH_HKEY;
                end else begin
                    cur.byte_class = hrft_pkg::CLS_METHOD;
                    for (int k = 0; k < hrft_pkg::NUM_METHODS; k++) begin
                        if (r_pos >= {1'b0, hrft_pkg::METHOD_LENS[k]} ||
                            hrft_pkg::METHOD_NAMES[k][r_pos[2:0]] != b) begin
                            n_match[k] = 1'b0;
                        end
                    end
                    if (r_pos != 4'd15) begin
                        n_pos = r_pos + 4'd1;
                    end
                end
            end
            hrft_pkg::PH_PREPATH: begin
                if (b == hrft_pkg::CH_SLASH) begin
                    cur.byte_class = hrft_pkg::CLS_PATH;
                    n_phase        = hrft_pkg::PH_PATH;
                end else if (b == hrft_pkg::CH_SP) begin
                    n_phase = hrft_pkg::PH_VERSION;
                end else if (b == hrft_pkg::CH_LF) begin
                    n_phase = hrft_pkg::PH_HKEY;
                end
            end
            hrft_pkg::PH_PATH: begin
                if (b == hrft_pkg::CH_SP) begin
                    cur.item_end = 1'b1;
                    n_phase      = hrft_pkg::PH_VERSION;
                end else if (b == hrft_pkg::CH_QMARK) begin
                    cur.item_end = 1'b1;
                    n_phase      = hrft_pkg::PH_QKEY;
                end else if (b == hrft_pkg::CH_LF) begin
                    cur.item_end = 1'b1;
                    n_phase      = hrft_pkg::PH_HKEY;
                end else if (b != hrft_pkg::CH_CR) begin
                    cur.byte_class = hrft_pkg::CLS_PATH;
                end
            end
            hrft_pkg::PH_QKEY, hrft_pkg::PH_QVAL: begin
                cur.item_index = hrft_pkg::clamp_index({2'b00, r_qcnt});
                if (b == hrft_pkg::CH_SP || b == hrft_pkg::CH_LF || b == hrft_pkg::CH_AMP) begin
                    cur.item_end = 1'b1;
                    if (r_qcnt < 5'(hrft_pkg::MAX_QUERIES)) begin
                        n_qcnt = r_qcnt + 5'd1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (b == hrft_pkg::CH_SP) begin
                        n_phase = hrft_pkg::PH_VERSION;
                    end else if (b == hrft_pkg::CH_LF) begin
                        n_phase = hrft_pkg::PH_HKEY;
                    end else begin
                        n_phase = hrft_pkg::PH_QKEY;
                    end
                end else if (b == hrft_pkg::CH_EQ && r_phase == hrft_pkg::PH_QKEY) begin
                    cur.item_end = 1'b1;
                    n_phase      = hrft_pkg::PH_QVAL;
                end else if (b != hrft_pkg::CH_QMARK && b != hrft_pkg::CH_CR) begin
                    cur.byte_class = (r_phase == hrft_pkg::PH_QKEY) ? hrft_pkg::CLS_QKEY
                                                                    : hrft_pkg::CLS_QVAL;
                end
            end
            hrft_pkg::PH_VERSION: begin
                if (b == hrft_pkg::CH_LF) begin
                    n_phase = hrft_pkg::PH_HKEY;
                end
            end
            hrft_pkg::PH_HKEY, hrft_pkg::PH_HVAL: begin
                if (b == hrft_pkg::CH_LF) begin
                    if (blank_line) begin
                        n_phase = hrft_pkg::PH_BODY;
                    end else begin
                        cur.item_index   = hrft_pkg::clamp_index(r_hcnt);
                        cur.item_end     = 1'b1;
                        cur.no_separator = !r_sep;
                        if (r_hcnt < 7'(hrft_pkg::MAX_HEADERS)) begin
                            n_hcnt = r_hcnt + 7'd1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_sep   = 1'b0;
                        n_phase = hrft_pkg::PH_HKEY;
                    end
                end else if (b != hrft_pkg::CH_CR) begin
                    cur.item_index = hrft_pkg::clamp_index(r_hcnt);
                    if (colon_space) begin
                        n_sep   = 1'b1;
                        n_phase = hrft_pkg::PH_HVAL;
                    end else begin
                        cur.byte_class = (r_phase == hrft_pkg::PH_HKEY) ? hrft_pkg::CLS_HKEY
                                                                        : hrft_pkg::CLS_HVAL;
                    end
                end
            end
            default: begin
                cur.byte_class = hrft_pkg::CLS_BODY;
            end
        endcase

        // Totals carry the counts as they stand after this byte.
        cur.query_total    = n_qcnt;
        cur.header_total   = n_hcnt;
        cur.count_overflow = n_ovf;
    end

    always_comb begin
        o_push.push_pend = i_accept && r_pend_valid;
        o_push.push_cur  = i_accept && i_word.end_of_request;
        o_push.pend_word = pend_out;
        o_push.cur_word  = cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= hrft_pkg::PH_METHOD;
            r_match      <= {hrft_pkg::NUM_METHODS{1'b1}};
            r_pos        <= 4'd0;
            r_qcnt       <= 5'd0;
            r_hcnt       <= 7'd0;
            r_blank      <= 2'd0;
            r_sep        <= 1'b0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (i_accept) begin
            if (i_word.end_of_request) begin
                r_phase      <= hrft_pkg::PH_METHOD;
                r_match      <= {hrft_pkg::NUM_METHODS{1'b1}};
                r_pos        <= 4'd0;
                r_qcnt       <= 5'd0;
                r_hcnt       <= 7'd0;
                r_blank      <= 2'd0;
                r_sep        <= 1'b0;
                r_ovf        <= 1'b0;
                r_pend_valid <= 1'b0;
            end else begin
                r_phase      <= n_phase;
                r_match      <= n_match;
                r_pos        <= n_pos;
                r_qcnt       <= n_qcnt;
                r_hcnt       <= n_hcnt;
                r_blank      <= n_blank;
                r_sep        <= n_sep;
                r_ovf        <= n_ovf;
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !i_word.end_of_request) begin
            r_pend <= cur;
        end
    end

endmodule

// ===== hdl/http_request_field_tagger.sv =====
// Top level of the HTTP request field tagger: byte parser plus output word queue.
//
// Input channel: i_in_valid / o_in_stall / i_in_word carry one request byte per word,
// with end_of_request marking the final byte of a request. Output channel:
// o_out_valid / i_out_stall / o_out_word carry one tagged byte per word.
// A word moves on a rising edge where valid is high and stall is low.
// Each byte's tag is decided when the following byte arrives, because a ':'
// in a header key only becomes the separator if a space follows it. So the
// result for byte N is queued when byte N+1 is accepted. On the final byte
// both the held result and the final one (with last set) are queued at once,
// and the parser returns to its reset state.
// Throughput is one byte per cycle while o_in_stall is low; the parser is a single level of compare
// and select logic between its state registers and a four-word output queue.
// The queue holds off input (o_in_stall) once three words are waiting, so a
// receiver that stalls fills the queue and then pushes back on the sender.
// Reset (synchronous, active low) empties the queue and sets the parser to
// the start of a request.
`include "http_request_field_tagger_macros.svh"

module http_request_field_tagger (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hrft_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hrft_pkg::t_out_word o_out_word
);

    logic                               in_accept;
    logic                               out_accept;
    hrft_pkg::t_push                    push;

    // Output queue; entries are payload only, the count tracks occupancy.
    hrft_pkg::t_out_word                r_fifo [hrft_pkg::FIFO_DEPTH];
    logic [hrft_pkg::PTR_W-1:0]         r_wr_ptr, n_wr_ptr;
    logic [hrft_pkg::PTR_W-1:0]         r_rd_ptr, n_rd_ptr;
    logic [hrft_pkg::CNT_W-1:0]         r_count, n_count;
    logic [hrft_pkg::PTR_W-1:0]         wr_ptr_nx;

    // Stall depends on the queue fill only, so it never waits on valid.
    assign o_in_stall  = (r_count > hrft_pkg::CNT_W'(hrft_pkg::FIFO_DEPTH - 2));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign out_accept  = o_out_valid && !i_out_stall;
    assign o_out_word  = r_fifo[r_rd_ptr];
    assign wr_ptr_nx   = r_wr_ptr + hrft_pkg::PTR_W'(1);

    hrft_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_word   (i_in_word),
        .o_push   (push)
    );

    // One accepted byte can queue zero, one or two words.
    always_comb begin
        n_wr_ptr = r_wr_ptr + hrft_pkg::PTR_W'(push.push_pend) + hrft_pkg::PTR_W'(push.push_cur);
        n_rd_ptr = r_rd_ptr + hrft_pkg::PTR_W'(out_accept);
        n_count  = r_count + hrft_pkg::CNT_W'(push.push_pend)
                           + hrft_pkg::CNT_W'(push.push_cur)
                           - hrft_pkg::CNT_W'(out_accept);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // The held word goes in first so that words leave in byte order.
    always_ff @(posedge i_clk) begin
        if (push.push_pend) begin
            r_fifo[r_wr_ptr] <= push.pend_word;
            if (push.push_cur) begin
                r_fifo[wr_ptr_nx] <= push.cur_word;
            end
        end else if (push.push_cur) begin
            r_fifo[r_wr_ptr] <= push.cur_word;
        end
    end

    // The queue never holds more words than it has entries.
    `HRFT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= hrft_pkg::CNT_W'(hrft_pkg::FIFO_DEPTH))

    // The final byte of a request always leaves at least one word queued.
    `HRFT_ASSERT_NEXT(a_eor_queued, in_accept && i_in_word.end_of_request, r_count != '0)

    // A method report is always carried on a delimiter byte.
    `HRFT_ASSERT_NOW(a_method_on_delim, o_out_valid && o_out_word.method_done,
        o_out_word.byte_class == hrft_pkg::CLS_DELIM)

    // Totals saturate at their limits.
    `HRFT_ASSERT_NOW(a_totals_bound, o_out_valid,
        (o_out_word.query_total <= 5'(hrft_pkg::MAX_QUERIES)) &&
        (o_out_word.header_total <= 7'(hrft_pkg::MAX_HEADERS)))

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the HTTP request field tagger: directed requests, then random ones.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Method codes in the order the tagger reports them.
    typedef enum logic [3:0] {
        VERB_GET, VERB_POST, VERB_HEAD, VERB_PUT, VERB_DELETE,
        VERB_CONNECT, VERB_OPTIONS, VERB_TRACE, VERB_PATCH
    } t_verb;

    // How far along a CR LF CR LF run the byte stream is.
    localparam logic [1:0] SEEN_NONE   = 2'd0;
    localparam logic [1:0] SEEN_CR     = 2'd1;
    localparam logic [1:0] SEEN_CRLF   = 2'd2;
    localparam logic [1:0] SEEN_CRLFCR = 2'd3;

    // One directed request. A pinned row is a single byte sent from the idle
    // state whose tag is typed in here instead of being predicted.
    typedef struct {
        string               text;
        bit                  pinned;
        logic [7:0]          lone;
        hrft_pkg::t_out_word want;
    } t_row;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    hrft_pkg::t_in_word  in_word;
    logic                out_valid;
    logic                out_stall;
    hrft_pkg::t_out_word out_word;

    http_request_field_tagger u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    // Idle rates of the two sides, in percent.
    int send_idle_pct = 7;
    int out_stall_pct = 70;

    int errors     = 0;
    int words_seen = 0;

    // Tags still owed by the tagger, oldest first.
    hrft_pkg::t_out_word tags_due[$];

    // Set by the driver for a pinned row; the tag predicted for its final
    // byte is then replaced with the typed one.
    bit                  pin_on = 1'b0;
    hrft_pkg::t_out_word pin_word = '0;

    // Bytes of the request being sent.
    logic [7:0] req[$];

    // Tracked state of the tagger.
    hrft_pkg::t_phase    ph;
    logic [8:0]          meth_live;
    logic [3:0]          meth_pos;
    logic [4:0]          q_count;
    logic [6:0]          h_count;
    logic [1:0]          crlf_run;
    hrft_pkg::t_out_word held;
    logic                held_valid;
    logic                sep_seen;
    logic                ovf;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run should be over long before this.
    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic string verb_text(input t_verb v);
        case (v)
            VERB_GET:     return "GET";
            VERB_POST:    return "POST";
            VERB_HEAD:    return "HEAD";
            VERB_PUT:     return "PUT";
            VERB_DELETE:  return "DELETE";
            VERB_CONNECT: return "CONNECT";
            VERB_OPTIONS: return "OPTIONS";
            VERB_TRACE:   return "TRACE";
            default:      return "PATCH";
        endcase
    endfunction

    function automatic logic [5:0] index_cap(input logic [6:0] v);
        return (v > 7'd63) ? 6'd63 : v[5:0];
    endfunction

    function automatic void parser_restart();
        ph         = hrft_pkg::PH_METHOD;
        meth_live  = '1;
        meth_pos   = '0;
        q_count    = '0;
        h_count    = '0;
        crlf_run   = SEEN_NONE;
        held       = '0;
        held_valid = 1'b0;
        sep_seen   = 1'b0;
        ovf        = 1'b0;
    endfunction

    // A method is known only if its whole name matched and nothing followed.
    function automatic logic [3:0] verb_result();
        string name;
        for (int k = 0; k < hrft_pkg::NUM_METHODS; k++) begin
            name = verb_text(t_verb'(k));
            if (meth_live[k] && name.len() == meth_pos) return k[3:0];
        end
        return hrft_pkg::METHOD_UNKNOWN;
    endfunction

    function automatic void close_query();
        if (q_count < hrft_pkg::MAX_QUERIES) q_count++;
        else ovf = 1'b1;
    endfunction

    function automatic void close_header();
        if (h_count < hrft_pkg::MAX_HEADERS) h_count++;
        else ovf = 1'b1;
    endfunction

    // Works out the tag of one byte and moves the parse state along.
    // colon_space says the byte is the space of a ": " in a header key.
    function automatic hrft_pkg::t_out_word tag_byte(input logic [7:0] b,
                                                     input logic colon_space);
        hrft_pkg::t_out_word t;
        logic                blank;
        string               name;
        t = '0;
        t.data_byte = b;
        t.byte_class = hrft_pkg::CLS_DELIM;
        blank = 1'b0;

        if (b == hrft_pkg::CH_CR) begin
            crlf_run = (crlf_run == SEEN_CRLF) ? SEEN_CRLFCR : SEEN_CR;
        end else if (b == hrft_pkg::CH_LF) begin
            blank = (crlf_run == SEEN_CRLFCR);
            crlf_run = (crlf_run == SEEN_CR) ? SEEN_CRLF : SEEN_NONE;
        end else begin
            crlf_run = SEEN_NONE;
        end

        case (ph)
            hrft_pkg::PH_METHOD: begin
                if (b == hrft_pkg::CH_SP || b == hrft_pkg::CH_LF) begin
                    t.method_done = 1'b1;
                    t.method_code = (b == hrft_pkg::CH_SP) ? verb_result()
                                                           : hrft_pkg::METHOD_UNKNOWN;
                    ph = (b == hrft_pkg::CH_SP) ? hrft_pkg::PH_PREPATH : hrft_pkg::PH_HKEY;
                end else begin
                    t.byte_class = hrft_pkg::CLS_METHOD;
                    for (int k = 0; k < hrft_pkg::NUM_METHODS; k++) begin
                        name = verb_text(t_verb'(k));
                        if (meth_pos >= name.len() || name[meth_pos] != b) meth_live[k] = 1'b0;
                    end
                    if (meth_pos < 4'd15) meth_pos++;
                end
            end
            hrft_pkg::PH_PREPATH: begin
                if (b == hrft_pkg::CH_SLASH) begin
                    t.byte_class = hrft_pkg::CLS_PATH;
                    ph = hrft_pkg::PH_PATH;
                end else if (b == hrft_pkg::CH_SP) begin
                    ph = hrft_pkg::PH_VERSION;
                end else if (b == hrft_pkg::CH_LF) begin
                    ph = hrft_pkg::PH_HKEY;
                end
            end
            hrft_pkg::PH_PATH: begin
                if (b == hrft_pkg::CH_SP) begin
                    t.item_end = 1'b1;
                    ph = hrft_pkg::PH_VERSION;
                end else if (b == hrft_pkg::CH_QMARK) begin
                    t.item_end = 1'b1;
                    ph = hrft_pkg::PH_QKEY;
                end else if (b == hrft_pkg::CH_LF) begin
                    t.item_end = 1'b1;
                    ph = hrft_pkg::PH_HKEY;
                end else if (b != hrft_pkg::CH_CR) begin
                    t.byte_class = hrft_pkg::CLS_PATH;
                end
            end
            hrft_pkg::PH_QKEY, hrft_pkg::PH_QVAL: begin
                t.item_index = index_cap({2'b00, q_count});
                if (b == hrft_pkg::CH_SP || b == hrft_pkg::CH_LF || b == hrft_pkg::CH_AMP) begin
                    t.item_end = 1'b1;
                    close_query();
                    if (b == hrft_pkg::CH_SP) ph = hrft_pkg::PH_VERSION;
                    else if (b == hrft_pkg::CH_LF) ph = hrft_pkg::PH_HKEY;
                    else ph = hrft_pkg::PH_QKEY;
                end else if (b == hrft_pkg::CH_EQ && ph == hrft_pkg::PH_QKEY) begin
                    t.item_end = 1'b1;
                    ph = hrft_pkg::PH_QVAL;
                end else if (b != hrft_pkg::CH_QMARK && b != hrft_pkg::CH_CR) begin
                    t.byte_class = (ph == hrft_pkg::PH_QKEY) ? hrft_pkg::CLS_QKEY
                                                            : hrft_pkg::CLS_QVAL;
                end
            end
            hrft_pkg::PH_VERSION: begin
                if (b == hrft_pkg::CH_LF) ph = hrft_pkg::PH_HKEY;
            end
            hrft_pkg::PH_HKEY, hrft_pkg::PH_HVAL: begin
                if (b == hrft_pkg::CH_LF) begin
                    if (blank) begin
                        ph = hrft_pkg::PH_BODY;
                    end else begin
                        t.item_index = index_cap(h_count);
                        t.item_end = 1'b1;
                        t.no_separator = !sep_seen;
                        close_header();
                        sep_seen = 1'b0;
                        ph = hrft_pkg::PH_HKEY;
                    end
                end else if (b != hrft_pkg::CH_CR) begin
                    t.item_index = index_cap(h_count);
                    if (colon_space) begin
                        sep_seen = 1'b1;
                        ph = hrft_pkg::PH_HVAL;
                    end else begin
                        t.byte_class = (ph == hrft_pkg::PH_HKEY) ? hrft_pkg::CLS_HKEY
                                                                : hrft_pkg::CLS_HVAL;
                    end
                end
            end
            default: begin
                t.byte_class = hrft_pkg::CLS_BODY;
            end
        endcase
        return t;
    endfunction

    // The running totals a word carries are those in force when it is released.
    function automatic void owe_tag(input hrft_pkg::t_out_word t, input logic is_last);
        t.query_total = q_count;
        t.header_total = h_count;
        t.count_overflow = ovf;
        t.last = is_last;
        tags_due.push_back(t);
    endfunction

    // One accepted byte releases the tag held back from the byte before it,
    // and on the final byte of a request its own tag too.
    function automatic void predict_byte(input hrft_pkg::t_in_word w);
        logic                colon_space;
        hrft_pkg::t_out_word cur;
        colon_space = ph == hrft_pkg::PH_HKEY && held_valid &&
                      held.byte_class == hrft_pkg::CLS_HKEY &&
                      held.data_byte == hrft_pkg::CH_COLON && w.in_byte == hrft_pkg::CH_SP;
        if (colon_space) begin
            held.byte_class = hrft_pkg::CLS_DELIM;
            held.item_end = 1'b1;
        end
        if (held_valid) owe_tag(held, 1'b0);
        cur = tag_byte(w.in_byte, colon_space);
        if (w.end_of_request) begin
            owe_tag(cur, 1'b1);
            parser_restart();
        end else begin
            held = cur;
            held_valid = 1'b1;
        end
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        $display("[%0t] tagger error: %s", $time, msg);
    endtask

    task automatic diff_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want) begin
            flag_error($sformatf("word %0d %s is %0h, expected %0h", words_seen, name, got, want));
        end
    endtask

    task automatic check_word(input hrft_pkg::t_out_word got);
        hrft_pkg::t_out_word want;
        if (tags_due.size() == 0) begin
            flag_error($sformatf("word %0d (byte %0h) arrived with nothing owed",
                                 words_seen, got.data_byte));
        end else begin
            want = tags_due.pop_front();
            diff_field("data_byte", got.data_byte, want.data_byte);
            diff_field("byte_class", got.byte_class, want.byte_class);
            diff_field("item_index", got.item_index, want.item_index);
            diff_field("item_end", got.item_end, want.item_end);
            diff_field("method_code", got.method_code, want.method_code);
            diff_field("method_done", got.method_done, want.method_done);
            diff_field("no_separator", got.no_separator, want.no_separator);
            diff_field("query_total", got.query_total, want.query_total);
            diff_field("header_total", got.header_total, want.header_total);
            diff_field("count_overflow", got.count_overflow, want.count_overflow);
            diff_field("last", got.last, want.last);
        end
        words_seen++;
    endtask

    // Output words are checked before the word taken in at the same edge is
    // predicted, all in one process, so ordering within the edge never matters.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) check_word(out_word);
            if (in_valid && !in_stall) begin
                predict_byte(in_word);
                if (pin_on && in_word.end_of_request) tags_due[tags_due.size() - 1] = pin_word;
            end
        end
    end

    // The receiver holds off at random.
    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_byte(input logic [7:0] b, input logic eor, input bit pin,
                             input hrft_pkg::t_out_word pin_w);
        pin_on = pin;
        pin_word = pin_w;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{in_byte: b, end_of_request: eor};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_request();
        for (int i = 0; i < req.size(); i++) begin
            send_byte(req[i], i == req.size() - 1, 1'b0, '0);
        end
    endtask

    function automatic string repeat_text(input string s, input int n);
        string r;
        r = "";
        repeat (n) r = {r, s};
        return r;
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) req.push_back(s[i]);
    endfunction

    // A run of letters and digits, now and then one of the bytes in extra.
    function automatic void word_run(input int n, input string extra);
        repeat (n) begin
            if (extra.len() != 0 && $urandom_range(5) == 0) begin
                req.push_back(extra[$urandom_range(extra.len() - 1)]);
            end else if ($urandom_range(3) == 0) begin
                req.push_back($urandom_range("0", "9"));
            end else begin
                req.push_back($urandom_range("a", "z"));
            end
        end
    endfunction

    // Noise leans on the bytes the parser reacts to.
    function automatic logic [7:0] noise_byte();
        string marks;
        marks = " \n\015/?&=:";
        if ($urandom_range(1) == 0) return marks[$urandom_range(marks.len() - 1)];
        return $urandom_range(255);
    endfunction

    // Mostly well-formed requests with random content; some are cut short and
    // some are plain noise.
    function automatic void make_request();
        int nq;
        int nh;
        int cut;
        req.delete();
        if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(1, 24)) req.push_back(noise_byte());
            return;
        end

        if ($urandom_range(9) == 0) word_run($urandom_range(0, 8), "");
        else put_text(verb_text(t_verb'($urandom_range(hrft_pkg::NUM_METHODS - 1))));

        if ($urandom_range(19) == 0) begin
            put_text("\n");
        end else begin
            put_text(" ");
            if ($urandom_range(7) == 0) word_run($urandom_range(0, 4), "");
            put_text("/");
            word_run($urandom_range(0, 6), "/.-");
            if ($urandom_range(1) == 1) begin
                put_text("?");
                nq = ($urandom_range(24) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 3);
                for (int i = 0; i < nq; i++) begin
                    if (i > 0) put_text("&");
                    word_run($urandom_range(0, 4), "");
                    if ($urandom_range(2) != 0) begin
                        put_text("=");
                        word_run($urandom_range(0, 5), "/=?");
                    end
                end
            end
            put_text(($urandom_range(7) == 0) ? " HTTP/1.1\n" : " HTTP/1.1\015\n");
        end

        // Now and then enough short header lines to run the count past its limit.
        nh = ($urandom_range(29) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 4);
        for (int i = 0; i < nh; i++) begin
            if (nh > 8) begin
                put_text("k\n");
            end else begin
                word_run($urandom_range(1, 6), "-");
                case ($urandom_range(5))
                    0: begin
                        put_text(":");
                        word_run($urandom_range(0, 4), "");
                    end
                    1: ;
                    default: begin
                        put_text(": ");
                        word_run($urandom_range(0, 8), ": /");
                    end
                endcase
                put_text(($urandom_range(5) == 0) ? "\n" : "\015\n");
            end
        end
        put_text("\015\n");
        repeat ($urandom_range(0, 6)) req.push_back($urandom_range(255));

        if ($urandom_range(5) == 0) begin
            cut = $urandom_range(1, req.size());
            while (req.size() > cut) void'(req.pop_back());
        end
    endfunction

    initial begin
        t_row plan[$];
        t_row row;
        int   sent;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        parser_restart();

        // Lone bytes from the idle state, with tags that can be read off directly.
        row.text = "";
        row.pinned = 1'b1;
        row.lone = 8'hFF;
        row.want = '{data_byte: 8'hFF, byte_class: hrft_pkg::CLS_METHOD, last: 1'b1,
                     default: '0};
        plan.push_back(row);
        row.lone = 8'h00;
        row.want = '{data_byte: 8'h00, byte_class: hrft_pkg::CLS_METHOD, last: 1'b1,
                     default: '0};
        plan.push_back(row);
        row.lone = hrft_pkg::CH_LF;
        row.want = '{data_byte: hrft_pkg::CH_LF, byte_class: hrft_pkg::CLS_DELIM,
                     method_code: hrft_pkg::METHOD_UNKNOWN,
                     method_done: 1'b1, last: 1'b1, default: '0};
        plan.push_back(row);
        row.lone = hrft_pkg::CH_SP;
        row.want = '{data_byte: hrft_pkg::CH_SP, byte_class: hrft_pkg::CLS_DELIM,
                     method_code: hrft_pkg::METHOD_UNKNOWN,
                     method_done: 1'b1, last: 1'b1, default: '0};
        plan.push_back(row);

        // Whole requests, checked against the prediction.
        row.pinned = 1'b0;
        row.lone = '0;
        row.want = '0;
        foreach (plan[i]) begin end
        row.text = "GET / HTTP/1.1\015\nHost: a\015\n\015\nhi";
        plan.push_back(row);
        // Query key without value, value, and a query closed by the space.
        row.text = "POST /p?a=b&c HTTP/1.0\015\n\015\n";
        plan.push_back(row);
        // A slash and a second '?' inside a query, and '=' inside a value.
        row.text = "HEAD /x?k/v=1=2?q&z=/ HTTP/1.1\n";
        plan.push_back(row);
        // A target without any slash ends with no path.
        row.text = "PUT ab cd\015\n";
        plan.push_back(row);
        // Bytes ahead of the slash are delimiters.
        row.text = "DELETE zz/y?q \n";
        plan.push_back(row);
        // Empty queries still count.
        row.text = "CONNECT /?&& \n";
        plan.push_back(row);
        // A query closed by the line feed, then a header.
        row.text = "OPTIONS /a?b\nK: v\n";
        plan.push_back(row);
        // A colon with no space, a colon inside a value, a line with no
        // separator, a bare line feed blank line, then the real end of headers.
        row.text = "TRACE / H\015\nK:v\015\nA: b:c\015\nX\n\n\015\n\015\nbody";
        plan.push_back(row);
        row.text = "PATCH /\015\n\015\n\015\n";
        plan.push_back(row);
        // Method names with a byte too many, or too few.
        row.text = "GETX / \n";
        plan.push_back(row);
        row.text = "GE / \n";
        plan.push_back(row);
        // A line feed ends the method and starts the headers.
        row.text = "PUTT\nk: v\015\n";
        plan.push_back(row);
        row.text = "\nk: v\015\n";
        plan.push_back(row);
        row.text = " / \n";
        plan.push_back(row);
        row.text = "GET /a:b HTTP\015\nKey: v\015\nK\015y: z\n";
        plan.push_back(row);
        row.text = "\377\200 x";
        plan.push_back(row);
        // Both counts pushed past their limits; the flag clears with the next request.
        row.text = {"GET /?", repeat_text("&", 18), " \n"};
        plan.push_back(row);
        row.text = {"\n", repeat_text("\n", 66)};
        plan.push_back(row);
        row.text = "GET /\n";
        plan.push_back(row);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // The sender idles rarely and the receiver often, for the directed part
        // and the first third of the random part.
        foreach (plan[i]) begin
            if (plan[i].pinned) begin
                send_byte(plan[i].lone, 1'b1, 1'b1, plan[i].want);
            end else begin
                req.delete();
                put_text(plan[i].text);
                send_request();
            end
        end

        sent = 0;
        while (sent < 1900) begin
            if (sent >= 1266) begin
                send_idle_pct = 0;
                out_stall_pct = 0;
            end else if (sent >= 633) begin
                send_idle_pct = 70;
                out_stall_pct = 7;
            end
            make_request();
            send_request();
            sent += req.size();
        end
        in_valid <= 1'b0;

        // Drain, then give the tagger time to show any word it should not send.
        while (tags_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
